@@ src/dmg_pkg.sv @@
// ----------------------------------------------------------------------------
// dmg_pkg
// Shared types, constants and helpers of the minimum-elevation grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmg_pkg;

  // Default grid capacity.
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Largest cell shift in effect; larger settings saturate here.
  localparam logic [4:0] SHIFT_LIMIT = 5'd20;

  // Multiply-accumulate widths.
  localparam int MA_W  = 33;
  localparam int MB_W  = 22;
  localparam int ACC_W = 58;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_SHIFT_X   = 3'd2;
  localparam logic [2:0] CFG_SHIFT_Y   = 3'd3;
  localparam logic [2:0] CFG_GRID_COLS = 3'd4;
  localparam logic [2:0] CFG_GRID_ROWS = 3'd5;
  localparam logic [2:0] CFG_GROUND    = 3'd6;

  // Function codes of an item.
  localparam logic [1:0] FUNC_INSERT   = 2'd0;
  localparam logic [1:0] FUNC_CELL     = 2'd1;
  localparam logic [1:0] FUNC_BILINEAR = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIFF, S_GRID, S_ADDR,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
    S_FIN
  } state_t;

  // Accumulator control of the shared multiplier.
  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  // Saturating z minus ground elevation.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] z,
                                                 input logic signed [32:0] g);
    logic signed [33:0] diff;
    logic signed [31:0] res;
    diff = {{2{z[31]}}, z} - {g[32], g};
    if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
      res = diff[31:0];
    end else if (diff[33]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/dmg_cell_ram.sv @@
// ----------------------------------------------------------------------------
// dmg_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmg_cell_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 33
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/dmg_mac.sv @@
// ----------------------------------------------------------------------------
// dmg_mac
// Shared multiplier with a product register and an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module dmg_mac (
  input  wire logic                              clk,
  input  wire dmg_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [dmg_pkg::MA_W-1:0]   op_a,
  input  wire logic signed [dmg_pkg::MB_W-1:0]   op_b,
  output logic signed [dmg_pkg::ACC_W-1:0]       acc
);

  import dmg_pkg::*;

  logic signed [MA_W+MB_W-1:0] prod_r;

  // Product stage.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Accumulate the previous product, or load it alone.
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc <= (ctl.acc_clr ? '0 : acc)
           + {{(ACC_W-MA_W-MB_W){prod_r[MA_W+MB_W-1]}}, prod_r};
    end
  end

endmodule

`default_nettype wire

@@ src/dem_min_grid_bilinear_subtract.sv @@
// ----------------------------------------------------------------------------
// dem_min_grid_bilinear_subtract
// Minimum-elevation grid with cell and bilinear height subtraction.
// ----------------------------------------------------------------------------
// The block works on one item at a time. An insert or a cell subtraction reads
// the own cell once, an off-grid point or an unused code reads no cell, and a
// bilinear subtraction with a filled own cell is paced by the single read port
// of the cell store (four reads) and the one shared multiplier (eight products).
// The next item is taken in the cycle after the output register loads. A result
// waiting in the output register does not hold off the next item.
// After reset the cell store is cleared one entry a cycle, all MAX_COLS*MAX_ROWS
// entries (4096 by default), while in_ready stays low; configuration writes are
// taken throughout.
`default_nettype none

module dem_min_grid_bilinear_subtract #(
  parameter int MAX_COLS = dmg_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = dmg_pkg::DEF_MAX_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_z,
  output logic                    out_outside_grid,
  output logic                    out_cell_empty,
  output logic                    out_below_ground,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  import dmg_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);

  // Configuration registers.
  logic signed [31:0] origin_x_r, origin_y_r, ground_r;
  logic [4:0]         shift_x_r, shift_y_r;
  logic [6:0]         cols_r, rows_r;

  // Sequencer and item state.
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic [1:0]         func_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [32:0] dx_r, dy_r, ix_r, iy_r;
  logic [20:0]        fx_r, fy_r;
  logic               own_in_r, x1_in_r, y1_in_r;
  logic [AW-1:0]      addr0_r, addr1_r, addr2_r, addr3_r;
  logic signed [31:0] f0_r, f1_r, f2_r, f3_r;
  logic signed [ACC_W-1:0] a_r;
  logic signed [32:0] aq_r, bq_r;
  logic [20:0]        ar_r, br_r, rq_r;
  logic signed [31:0] res_r;
  logic               outside_r, empty_r;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_z_r;
  logic               out_outside_r, out_empty_r, out_below_r;

  // Memory and multiplier connections.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [32:0]        mem_wdata, mem_rdata;
  mac_ctl_t           mac_ctl;
  logic signed [MA_W-1:0]  mac_a;
  logic signed [MB_W-1:0]  mac_b;
  logic signed [ACC_W-1:0] acc;

  // Derived combinational values.
  logic [4:0]         sx, sy;
  logic [20:0]        mask_x, mask_y;
  logic signed [21:0] w_s, h_s;
  logic signed [33:0] ix_e, iy_e, cols_e, rows_e;
  logic signed [32:0] ix_c, iy_c;
  logic signed [31:0] rd_val, ins_val;
  logic               rd_ok, fin_load;
  logic [ACC_W-1:0]   g_sum;
  logic signed [ACC_W-1:0] g_full;

  assign sx     = (shift_x_r > SHIFT_LIMIT) ? SHIFT_LIMIT : shift_x_r;
  assign sy     = (shift_y_r > SHIFT_LIMIT) ? SHIFT_LIMIT : shift_y_r;
  assign mask_x = (21'd1 << sx) - 21'd1;
  assign mask_y = (21'd1 << sy) - 21'd1;
  assign w_s    = $signed(22'd1 << sx);
  assign h_s    = $signed(22'd1 << sy);

  // Cell index is a floor shift of the offset from the origin.
  assign ix_c   = dx_r >>> sx;
  assign iy_c   = dy_r >>> sy;
  assign ix_e   = {ix_c[32], ix_c};
  assign iy_e   = {iy_c[32], iy_c};
  assign cols_e = (34'(cols_r) > 34'(MAX_COLS)) ? 34'(MAX_COLS) : 34'(cols_r);
  assign rows_e = (34'(rows_r) > 34'(MAX_ROWS)) ? 34'(MAX_ROWS) : 34'(rows_r);

  assign rd_val  = $signed(mem_rdata[31:0]);
  assign rd_ok   = mem_rdata[32];
  assign ins_val = (!rd_ok || z_r < rd_val) ? z_r : rd_val;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign g_sum  = acc + ACC_W'(rq_r);
  assign g_full = $signed(g_sum) >>> sy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      ground_r   <= '0;
      shift_x_r  <= 5'd8;
      shift_y_r  <= 5'd8;
      cols_r     <= 7'd64;
      rows_r     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:  origin_x_r <= $signed(cfg_wdata);
        CFG_ORIGIN_Y:  origin_y_r <= $signed(cfg_wdata);
        CFG_SHIFT_X:   shift_x_r  <= cfg_wdata[4:0];
        CFG_SHIFT_Y:   shift_y_r  <= cfg_wdata[4:0];
        CFG_GRID_COLS: cols_r     <= cfg_wdata[6:0];
        CFG_GRID_ROWS: rows_r     <= cfg_wdata[6:0];
        CFG_GROUND:    ground_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // State register and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Next state, memory ports and multiplier control.
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr0_r;
    mem_wdata   = {1'b1, ins_val};
    mem_raddr   = addr0_r;
    mac_ctl     = '0;
    mac_a       = '0;
    mac_b       = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_GRID;
      S_GRID: state_nxt = S_ADDR;
      S_ADDR: begin
        if (func_r == FUNC_UNUSED || !own_in_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        mem_raddr = addr2_r;
        if (func_r == FUNC_INSERT) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else if (func_r == FUNC_BILINEAR && rd_ok) begin
          state_nxt = S_RD2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD2: begin
        mem_raddr = addr1_r;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        mem_raddr = addr3_r;
        state_nxt = S_RD4;
      end
      S_RD4: state_nxt = S_A0;
      // Row sums a = f0*(w-fx) + f2*fx and b = f1*(w-fx) + f3*fx.
      S_A0: begin
        mac_a = MA_W'(f0_r);
        mac_b = w_s - $signed({1'b0, fx_r});
        state_nxt = S_A1;
      end
      S_A1: begin
        mac_a = MA_W'(f2_r);
        mac_b = $signed({1'b0, fx_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1};
        state_nxt = S_A2;
      end
      S_A2: begin
        mac_a = MA_W'(f1_r);
        mac_b = w_s - $signed({1'b0, fx_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b0};
        state_nxt = S_A3;
      end
      S_A3: begin
        mac_a = MA_W'(f3_r);
        mac_b = $signed({1'b0, fx_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1};
        state_nxt = S_A4;
      end
      S_A4: begin
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b0};
        state_nxt = S_A5;
      end
      S_A5: state_nxt = S_B0;
      // Column blend: remainders first, then quotients.
      S_B0: begin
        mac_a = $signed({12'd0, ar_r});
        mac_b = h_s - $signed({1'b0, fy_r});
        state_nxt = S_B1;
      end
      S_B1: begin
        mac_a = $signed({12'd0, br_r});
        mac_b = $signed({1'b0, fy_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1};
        state_nxt = S_B2;
      end
      S_B2: begin
        mac_a = aq_r;
        mac_b = h_s - $signed({1'b0, fy_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b0};
        state_nxt = S_B3;
      end
      S_B3: begin
        mac_a = bq_r;
        mac_b = $signed({1'b0, fy_r});
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1};
        state_nxt = S_B4;
      end
      S_B4: begin
        mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b0};
        state_nxt = S_B5;
      end
      S_B5: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        func_r <= in_func;
        x_r    <= in_x;
        y_r    <= in_y;
        z_r    <= in_z;
      end
      S_DIFF: begin
        dx_r <= {x_r[31], x_r} - {origin_x_r[31], origin_x_r};
        dy_r <= {y_r[31], y_r} - {origin_y_r[31], origin_y_r};
      end
      S_GRID: begin
        ix_r     <= ix_c;
        iy_r     <= iy_c;
        fx_r     <= dx_r[20:0] & mask_x;
        fy_r     <= dy_r[20:0] & mask_y;
        own_in_r <= !ix_c[32] && !iy_c[32] && (ix_e < cols_e) && (iy_e < rows_e);
        x1_in_r  <= (ix_e + 34'sd1) < cols_e;
        y1_in_r  <= (iy_e + 34'sd1) < rows_e;
      end
      S_ADDR: begin
        addr0_r <= AW'(iy_r[RW-1:0]) * AW'(MAX_COLS) + AW'(ix_r[CW-1:0]);
        addr2_r <= AW'(iy_r[RW-1:0]) * AW'(MAX_COLS) + AW'(ix_r[CW-1:0]) + AW'(1);
        addr1_r <= (AW'(iy_r[RW-1:0]) + AW'(1)) * AW'(MAX_COLS) + AW'(ix_r[CW-1:0]);
        addr3_r <= (AW'(iy_r[RW-1:0]) + AW'(1)) * AW'(MAX_COLS)
                 + AW'(ix_r[CW-1:0]) + AW'(1);
        res_r     <= z_r;
        outside_r <= (func_r != FUNC_UNUSED) && !own_in_r;
        empty_r   <= 1'b0;
      end
      S_RD1: begin
        f0_r    <= rd_val;
        empty_r <= !rd_ok;
        if (func_r == FUNC_INSERT) begin
          res_r <= ins_val;
        end else if (func_r == FUNC_CELL && rd_ok) begin
          res_r <= sat_sub(z_r, {rd_val[31], rd_val});
        end
      end
      // Missing or off-grid neighbours fall back to the own cell.
      S_RD2: f2_r <= (x1_in_r && rd_ok) ? rd_val : f0_r;
      S_RD3: f1_r <= (y1_in_r && rd_ok) ? rd_val : f0_r;
      S_RD4: f3_r <= (x1_in_r && y1_in_r && rd_ok) ? rd_val : f0_r;
      S_A3:  a_r  <= acc;
      S_A5: begin
        aq_r <= 33'(a_r >>> sx);
        ar_r <= a_r[20:0] & mask_x;
        bq_r <= 33'(acc >>> sx);
        br_r <= acc[20:0] & mask_x;
      end
      S_B3:  rq_r  <= 21'(acc >>> sx);
      S_B5:  res_r <= sat_sub(z_r, g_full[32:0]);
      default: ;
    endcase
  end

  // Output register: loads when the slot is free or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_z_r       <= res_r;
      out_outside_r <= outside_r;
      out_empty_r   <= empty_r;
      out_below_r   <= res_r < ground_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_z     = out_z_r;
  assign out_outside_grid = out_outside_r;
  assign out_cell_empty   = out_empty_r;
  assign out_below_ground = out_below_r;

  // Cell store: valid bit over 32-bit elevation.
  dmg_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (33)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared multiplier for the bilinear blend.
  dmg_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

`ifndef SYNTHESIS
  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  // The store is written only by the clearing pass or an insert.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || (state_r == S_RD1 && func_r == FUNC_INSERT)))
    else $error("unexpected cell store write");

  // An off-grid point never reports an empty cell.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_outside_grid && out_cell_empty))
    else $error("outside and empty both set");
`endif

endmodule

`default_nettype wire
